### rtl/xsti_pkg.sv
// Package for the cross-section table interpolator: codes, grid constants,
// reciprocal constants and the mass-segment helper functions.
// No dependencies.
package xsti_pkg;

    // Action codes of an input word
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INTERP  = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    localparam logic [31:0] NEG_ONE_Q16  = 32'hFFFF_0000;
    localparam logic [3:0]  VALID_ENERGY = 4'd7;

    // Grid boundaries in Q10.6
    localparam logic [15:0] MASS_90   = 16'd5760;
    localparam logic [15:0] MASS_200  = 16'd12800;
    localparam logic [15:0] MASS_300  = 16'd19200;
    localparam logic [15:0] MASS_400  = 16'd25600;
    localparam logic [15:0] MASS_1000 = 16'd64000;

    // Segment codes: step 5, 10, 20 and 50
    localparam logic [1:0] SEG_5  = 2'd0;
    localparam logic [1:0] SEG_10 = 2'd1;
    localparam logic [1:0] SEG_20 = 2'd2;
    localparam logic [1:0] SEG_50 = 2'd3;

    // floor(a/5) and floor(a/25) as (a*m) >> 44, exact for a < 2^38
    localparam logic [41:0] RECIP5_K44  = 42'd3518437208884;
    localparam logic [41:0] RECIP25_K44 = 42'd703687441777;
    // floor(a/25) as (a*m) >> 35, exact for a <= 2^29
    localparam logic [30:0] RECIP25_K35 = 31'd1374389535;

    // Clock edges from acceptance to the result strobe
    localparam int PIPE_DEPTH = 8;

    typedef struct packed {
        logic [1:0] status;
        logic       err_tab;
        logic [1:0] seg;
    } xsti_meta_t;

    function automatic logic [15:0] seg_start(input logic [1:0] seg);
        logic [15:0] s;
        unique case (seg)
            SEG_5:   s = MASS_90;
            SEG_10:  s = MASS_200;
            SEG_20:  s = MASS_300;
            default: s = MASS_400;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] seg_offset(input logic [1:0] seg);
        logic [5:0] o;
        unique case (seg)
            SEG_5:   o = 6'd0;
            SEG_10:  o = 6'd22;
            SEG_20:  o = 6'd32;
            default: o = 6'd37;
        endcase
        return o;
    endfunction

    function automatic logic [5:0] seg_step(input logic [1:0] seg);
        logic [5:0] st;
        unique case (seg)
            SEG_5:   st = 6'd5;
            SEG_10:  st = 6'd10;
            SEG_20:  st = 6'd20;
            default: st = 6'd50;
        endcase
        return st;
    endfunction

    // Power-of-two part of the step (step = 2^k * 5 or 2^k * 25)
    function automatic logic [1:0] seg_pow2(input logic [1:0] seg);
        logic [1:0] k;
        unique case (seg)
            SEG_5:   k = 2'd0;
            SEG_10:  k = 2'd1;
            SEG_20:  k = 2'd2;
            default: k = 2'd1;
        endcase
        return k;
    endfunction

    // Whole-GeV distance divided by the step, by reciprocal multiply
    function automatic logic [7:0] seg_quot(input logic [1:0] seg, input logic [9:0] xi);
        logic [17:0] p;
        logic [7:0]  q;
        p = 18'(xi) * 18'd205;
        unique case (seg)
            SEG_5:   q = 8'(p >> 10);
            SEG_10:  q = 8'(p >> 11);
            SEG_20:  q = 8'(p >> 12);
            default: q = 8'((18'(xi) * 18'd41) >> 11);
        endcase
        return q;
    endfunction

endpackage

### rtl/xsti_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read.
// No dependencies.
module xsti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2100,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, registered
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/cross_section_table_interpolator_core.sv
// Top level of the cross-section table interpolator: table RAM and an
// eight-stage interpolation pipeline. Depends on xsti_pkg and xsti_ram.
//
//  channel   | handshake           | fields
//  ----------+---------------------+-----------------------------------------
//  input     | start & !busy       | action, table_select, process_id, mass,
//            |                     | energy_tev, point_index, entry_value
//  result    | done (one cycle)    | value, status
//
// One word is taken every cycle; busy never rises. A query gives its result
// word from the output register after stages 1 to 7, a load gives none and
// writes the RAM from the stage 1 registers. The rate is set by the RAM's two
// read ports, which fetch both grid points of a segment together.
// rst_n clears the pipeline; the table RAM is not cleared and its entries
// are undefined until loaded. The receiver cannot stall, so nothing holds.
module cross_section_table_interpolator_core
    import xsti_pkg::*;
#(
    parameter int MASS_POINTS  = 50,
    parameter int TABLE_COUNT  = 7,
    parameter int PROCESS_ROWS = 6
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [2:0]         table_select,
    input  logic [2:0]         process_id,
    input  logic [15:0]        mass,
    input  logic [3:0]         energy_tev,
    input  logic [5:0]         point_index,
    input  logic signed [31:0] entry_value,
    output logic               done,
    output logic signed [31:0] value,
    output logic [1:0]         status
);

    localparam int DEPTH = TABLE_COUNT * PROCESS_ROWS * MASS_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_action_reg;
    logic [2:0]         s1_tbl_reg;
    logic [2:0]         s1_proc_reg;
    logic [15:0]        s1_mass_reg;
    logic [3:0]         s1_energy_reg;
    logic [5:0]         s1_pt_reg;
    logic [31:0]        s1_entry_reg;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_tbl_reg    <= table_select;
            s1_proc_reg   <= process_id;
            s1_mass_reg   <= mass;
            s1_energy_reg <= energy_tev;
            s1_pt_reg     <= point_index;
            s1_entry_reg  <= entry_value;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 logic: rules, segment search, RAM addresses and load write
    // ---------------------------------------------------------------
    logic [1:0]  status_next;
    logic [1:0]  seg_next;
    logic [15:0] x_s1;
    logic [7:0]  q_s1;
    logic [15:0] qstep_s1;
    logic [15:0] dx_full_s1;
    logic [11:0] dx_next;
    logic [5:0]  idx_s1;
    logic        lo_ok_next;
    logic        hi_ok_next;
    logic        tp_ok_s1;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_lo;
    logic [AW-1:0] rd_addr_hi;
    int          row_s1;

    assign tp_ok_s1 = (int'(s1_tbl_reg) < TABLE_COUNT) && (int'(s1_proc_reg) < PROCESS_ROWS);

    // Query rules in order of precedence
    always_comb
    begin
        priority if (!tp_ok_s1)
            status_next = ST_INVALID;
        else if (s1_tbl_reg != 3'd0 && s1_proc_reg == 3'd0)
            status_next = ST_ZERO;
        else if (s1_energy_reg != VALID_ENERGY)
            status_next = ST_INVALID;
        else if (s1_proc_reg > 3'd2 && s1_mass_reg > MASS_300)
            status_next = ST_ZERO;
        else if (s1_mass_reg < MASS_90 || s1_mass_reg > MASS_1000)
            status_next = ST_INVALID;
        else
            status_next = ST_INTERP;
    end

    // Segment of the grid
    always_comb
    begin
        priority if (s1_mass_reg <= MASS_200)
            seg_next = SEG_5;
        else if (s1_mass_reg <= MASS_300)
            seg_next = SEG_10;
        else if (s1_mass_reg <= MASS_400)
            seg_next = SEG_20;
        else
            seg_next = SEG_50;
    end

    // Grid index and raw distance from the lower point
    assign x_s1       = s1_mass_reg - seg_start(seg_next);
    assign q_s1       = seg_quot(seg_next, x_s1[15:6]);
    assign qstep_s1   = 16'(q_s1) * 16'(seg_step(seg_next));
    assign dx_full_s1 = x_s1 - {qstep_s1[9:0], 6'd0};
    assign dx_next    = dx_full_s1[11:0];
    assign idx_s1     = seg_offset(seg_next) + q_s1[5:0];
    assign lo_ok_next = int'(idx_s1) < MASS_POINTS;
    // On a grid point only the lower entry counts
    assign hi_ok_next = ((int'(idx_s1) + 1) < MASS_POINTS) && (dx_next != 12'd0);

    // RAM addressing: row-major over table, process, point
    assign row_s1     = int'(s1_tbl_reg) * PROCESS_ROWS + int'(s1_proc_reg);
    assign rd_addr_lo = AW'(row_s1 * MASS_POINTS + int'(idx_s1));
    assign rd_addr_hi = AW'(row_s1 * MASS_POINTS + int'(idx_s1) + 1);
    assign wr_addr    = AW'(row_s1 * MASS_POINTS + int'(s1_pt_reg));
    assign wr_en      = s1_valid_reg && (s1_action_reg == ACT_LOAD) && tp_ok_s1
                        && (int'(s1_pt_reg) < MASS_POINTS);

    logic [31:0] rd_lo;
    logic [31:0] rd_hi;

    xsti_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_table_ram (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (s1_entry_reg),
        .raddr_a (rd_addr_lo),
        .rdata_a (rd_lo),
        .raddr_b (rd_addr_hi),
        .rdata_b (rd_hi)
    );

    // ---------------------------------------------------------------
    // Stage 2: RAM data arrives, difference times distance
    // ---------------------------------------------------------------
    logic        s2_valid_reg;
    xsti_meta_t  s2_meta_reg;
    logic [11:0] s2_dx_reg;
    logic        s2_lo_ok_reg;
    logic        s2_hi_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && (s1_action_reg == ACT_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_meta_reg  <= '{status: status_next, err_tab: (s1_tbl_reg != 3'd0), seg: seg_next};
        s2_dx_reg    <= dx_next;
        s2_lo_ok_reg <= lo_ok_next;
        s2_hi_ok_reg <= hi_ok_next;
    end

    logic signed [31:0] lo_s2;
    logic signed [31:0] hi_s2;
    logic signed [32:0] diff_s2;
    logic signed [12:0] dx_s2;
    logic signed [45:0] prod_next;

    // Entries past the end of a row read as zero
    assign lo_s2     = s2_lo_ok_reg ? $signed(rd_lo) : 32'sd0;
    assign hi_s2     = s2_hi_ok_reg ? $signed(rd_hi) : 32'sd0;
    assign diff_s2   = 33'(hi_s2) - 33'(lo_s2);
    assign dx_s2     = $signed({1'b0, s2_dx_reg});
    assign prod_next = diff_s2 * dx_s2;

    // ---------------------------------------------------------------
    // Stage 3: magnitude, pre-shift, reciprocal partial products
    // ---------------------------------------------------------------
    logic               s3_valid_reg;
    xsti_meta_t         s3_meta_reg;
    logic signed [45:0] s3_prod_reg;
    logic signed [31:0] s3_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_meta_reg <= s2_meta_reg;
        s3_prod_reg <= prod_next;
        s3_lo_reg   <= lo_s2;
    end

    logic [45:0] mag_s3;
    logic [3:0]  sh_s3;
    logic [37:0] a_s3;
    logic [41:0] m_s3;
    logic [39:0] pp_ll_next;
    logic [39:0] pp_lh_next;
    logic [39:0] pp_hl_next;
    logic [39:0] pp_hh_next;

    assign mag_s3 = s3_prod_reg[45] ? 46'(-s3_prod_reg) : 46'(s3_prod_reg);
    assign sh_s3  = 4'd6 + 4'(seg_pow2(s3_meta_reg.seg));
    assign a_s3   = 38'(mag_s3 >> sh_s3);
    assign m_s3   = (s3_meta_reg.seg == SEG_50) ? RECIP25_K44 : RECIP5_K44;

    // Split the 38 x 42 product into four 19 x 21 parts
    assign pp_ll_next = 40'(a_s3[18:0])  * 40'(m_s3[20:0]);
    assign pp_lh_next = 40'(a_s3[18:0])  * 40'(m_s3[41:21]);
    assign pp_hl_next = 40'(a_s3[37:19]) * 40'(m_s3[20:0]);
    assign pp_hh_next = 40'(a_s3[37:19]) * 40'(m_s3[41:21]);

    // ---------------------------------------------------------------
    // Stage 4: combine partial products
    // ---------------------------------------------------------------
    logic               s4_valid_reg;
    xsti_meta_t         s4_meta_reg;
    logic               s4_neg_reg;
    logic signed [31:0] s4_lo_reg;
    logic [39:0]        s4_pp_ll_reg;
    logic [39:0]        s4_pp_lh_reg;
    logic [39:0]        s4_pp_hl_reg;
    logic [39:0]        s4_pp_hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_meta_reg  <= s3_meta_reg;
        s4_neg_reg   <= s3_prod_reg[45];
        s4_lo_reg    <= s3_lo_reg;
        s4_pp_ll_reg <= pp_ll_next;
        s4_pp_lh_reg <= pp_lh_next;
        s4_pp_hl_reg <= pp_hl_next;
        s4_pp_hh_reg <= pp_hh_next;
    end

    logic [79:0] cat_next;
    logic [61:0] mid_next;

    // High and low parts do not overlap, so they concatenate
    assign cat_next = {s4_pp_hh_reg, s4_pp_ll_reg};
    assign mid_next = (62'(s4_pp_hl_reg) << 19) + (62'(s4_pp_lh_reg) << 21);

    // ---------------------------------------------------------------
    // Stage 5: final sum, quotient, add to lower point
    // ---------------------------------------------------------------
    logic               s5_valid_reg;
    xsti_meta_t         s5_meta_reg;
    logic               s5_neg_reg;
    logic signed [31:0] s5_lo_reg;
    logic [79:0]        s5_cat_reg;
    logic [61:0]        s5_mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_meta_reg <= s4_meta_reg;
        s5_neg_reg  <= s4_neg_reg;
        s5_lo_reg   <= s4_lo_reg;
        s5_cat_reg  <= cat_next;
        s5_mid_reg  <= mid_next;
    end

    logic [79:0]        total_s5;
    logic [32:0]        q_s5;
    logic signed [33:0] qs_s5;
    logic signed [33:0] v_s5;

    // Quotient truncated toward zero, sign put back
    assign total_s5 = s5_cat_reg + 80'(s5_mid_reg);
    assign q_s5     = total_s5[76:44];
    assign qs_s5    = s5_neg_reg ? -$signed({1'b0, q_s5}) : $signed({1'b0, q_s5});
    assign v_s5     = 34'(s5_lo_reg) + qs_s5;

    // ---------------------------------------------------------------
    // Stage 6: error tables, magnitude divided by 100 (4 then 25)
    // ---------------------------------------------------------------
    logic               s6_valid_reg;
    xsti_meta_t         s6_meta_reg;
    logic signed [31:0] s6_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_meta_reg <= s5_meta_reg;
        s6_v_reg    <= v_s5[31:0];
    end

    logic [32:0] vmag_s6;
    logic [60:0] p100_next;

    assign vmag_s6   = s6_v_reg[31] ? 33'(-33'(s6_v_reg)) : 33'(s6_v_reg);
    assign p100_next = 61'(vmag_s6[31:2]) * 61'(RECIP25_K35);

    // ---------------------------------------------------------------
    // Stage 7: scaled result and rule override
    // ---------------------------------------------------------------
    logic               s7_valid_reg;
    xsti_meta_t         s7_meta_reg;
    logic signed [31:0] s7_v_reg;
    logic [60:0]        s7_p100_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_meta_reg <= s6_meta_reg;
        s7_v_reg    <= s6_v_reg;
        s7_p100_reg <= p100_next;
    end

    logic [25:0]        q100_s7;
    logic signed [31:0] scaled_s7;
    logic signed [31:0] interp_s7;
    logic [31:0]        value_next;

    assign q100_s7   = s7_p100_reg[60:35];
    assign scaled_s7 = s7_v_reg[31] ? -$signed(32'(q100_s7)) : $signed(32'(q100_s7));
    assign interp_s7 = s7_meta_reg.err_tab ? scaled_s7 : s7_v_reg;

    always_comb
    begin
        unique case (s7_meta_reg.status)
            ST_INTERP:  value_next = interp_s7;
            ST_INVALID: value_next = NEG_ONE_Q16;
            default:    value_next = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register: one-cycle result word
    // ---------------------------------------------------------------
    logic        done_reg;
    logic [31:0] value_reg;
    logic [1:0]  status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= s7_meta_reg.status;
    end

    assign done   = done_reg;
    assign value  = $signed(value_reg);
    assign status = status_reg;

endmodule

### rtl/xsti_checker.sv
// Port-level checker for the cross-section table interpolator, bound to the
// top level. Depends on xsti_pkg.
module xsti_checker
    import xsti_pkg::*;
#(
    parameter int TABLE_COUNT = 7
)(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               action,
    input logic [2:0]         table_select,
    input logic [2:0]         process_id,
    input logic [3:0]         energy_tev,
    input logic               done,
    input logic signed [31:0] value,
    input logic [1:0]         status
);

    logic [PIPE_DEPTH-1:0] qry_reg;
    logic [PIPE_DEPTH-1:0] bad_en_reg;
    logic                  qry_next;
    logic                  bad_en_next;

    // Queries accepted, and those the energy rule must reject
    assign qry_next    = start && !busy && (action == ACT_QUERY);
    assign bad_en_next = qry_next && (energy_tev != VALID_ENERGY)
                         && !(table_select != 3'd0 && process_id == 3'd0
                              && int'(table_select) < TABLE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qry_reg    <= '0;
            bad_en_reg <= '0;
        end
        else
        begin
            qry_reg    <= {qry_reg[PIPE_DEPTH-2:0], qry_next};
            bad_en_reg <= {bad_en_reg[PIPE_DEPTH-2:0], bad_en_next};
        end
    end

    // Exactly one result word per query, none per load
    a_one_word_per_query: assert property (@(posedge clk) disable iff (!rst_n)
        done == qry_reg[PIPE_DEPTH-1])
        else $error("result strobe does not match accepted queries");

    a_invalid_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_INVALID |-> value == $signed(NEG_ONE_Q16))
        else $error("invalid result without -1.0");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == ST_INTERP || status == ST_INVALID || status == ST_ZERO)
        else $error("unknown status code");

    a_energy_rule: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_en_reg[PIPE_DEPTH-1] |-> status == ST_INVALID)
        else $error("wrong energy not rejected");

endmodule

bind cross_section_table_interpolator_core xsti_checker #(
    .TABLE_COUNT (TABLE_COUNT)
) u_xsti_checker (.*);
